// ===== rtl/core/subtractive_lagged_rng_core_defines.svh =====
// Assertion macros shared by the subtractive lagged generator RTL.
`ifndef SUBTRACTIVE_LAGGED_RNG_CORE_DEFINES_SVH
`define SUBTRACTIVE_LAGGED_RNG_CORE_DEFINES_SVH

// Property that must hold at every sampled edge outside reset.
`define SRNG_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define SRNG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SRNG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/srng_pkg.sv =====
// Types and constants for the subtractive lagged generator.
package srng_pkg;

    localparam logic [30:0] MODULUS   = 31'h7FFF_FFFF;
    localparam logic [30:0] SEED_BASE = 31'd161803398;

    localparam logic [5:0]  TABLE_LEN = 6'd55;
    localparam logic [5:0]  FILL_LAST = 6'd54;
    localparam logic [5:0]  LAG_SHORT = 6'd21;
    localparam logic [5:0]  MIX_SPLIT = 6'd24;
    localparam logic [5:0]  MIX_FWD   = 6'd31;
    localparam logic [1:0]  MIX_PASS_LAST = 2'd3;

    localparam logic [31:0] WIDE_OFS  = 32'd2147483646;
    localparam logic [31:0] WIDE_DIV  = 32'hFFFF_FFFD;

    typedef enum logic [1:0] {
        OP_RESEED  = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BOUNDS   = 2'd1,
        STAT_UNSEEDED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_FILL,
        S_MIX_RD,
        S_MIX_WR,
        S_DRAW_RD,
        S_DRAW_WR,
        S_PREP,
        S_SCALE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic        wide;
        logic [31:0] n;
        logic [31:0] span;
    } scale_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } scale_resp_t;

endpackage

// ===== rtl/core/subtractive_lagged_rng_core.sv =====
// Top level of the subtractive lagged random generator.
//
// Subtractive lagged-Fibonacci generator, 55-entry table of 31-bit words, trail 21 ahead of lead,
// modulus 2^31-1. One item per transfer on s_*, one result per item on m_*. The block
// works on one item at a time and s_ready is high only while it is idle; a finished
// result sits in the output register, so the next item can be taken while the result
// waits. A raw draw takes one table step, a bounded draw a table step and the scaler, a
// bounded draw with a range above 2^31-1 two table steps and the scaler; errors and unused
// codes go straight to the result. A reseed folds the seed, makes 54 fill writes, runs four
// mixing passes of 55 entries with a read and a write each, then loads the result. The table
// memory has a registered read, so each table step costs a read and a write state through
// the single shared modular subtractor; the scaler is a four-stage multiplier. The table
// is not cleared at reset; draws before the first reseed are refused with status 2.
module subtractive_lagged_rng_core (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_seed_value,
    input  logic signed [31:0] s_range_low,
    input  logic signed [31:0] s_range_high,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic [1:0]         m_status
);

`include "subtractive_lagged_rng_core_defines.svh"

    // ---------------------------------------------------------------- state
    srng_pkg::state_t state_reg, state_next;

    logic        seeded_reg;
    logic [5:0]  lead_reg, trail_reg;
    logic        out_valid_reg, out_valid_next;

    // working registers
    logic [31:0] range_reg;        // seed magnitude on reseed, range on bounded draw
    logic [31:0] lo_reg;
    logic        bounded_reg;
    logic        second_reg;       // second draw of a wide bounded draw
    logic        par_reg;          // parity of the second draw
    logic [30:0] r1_reg;
    logic [30:0] mj_reg, mk_reg;
    logic [5:0]  slot_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  pass_reg;

    logic [31:0]       res_value_reg;
    srng_pkg::status_t res_status_reg;
    logic [31:0]       out_value_reg;
    srng_pkg::status_t out_status_reg;

    // ---------------------------------------------------------------- table
    logic [30:0] lag_mem [0:55];
    logic [30:0] rd_a_reg, rd_b_reg;
    logic        mem_we;
    logic [5:0]  mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [30:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lag_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= lag_mem[mem_raddr_a];
        rd_b_reg <= lag_mem[mem_raddr_b];
    end

    // ---------------------------------------------------------------- scaler
    srng_pkg::scale_req_t  scl_req;
    srng_pkg::scale_resp_t scl_resp;

    srng_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scl_req),
        .resp    (scl_resp)
    );

    // ---------------------------------------------------------------- datapath
    logic        s_fire;
    logic        out_free;
    logic [31:0] seed_mag;
    logic [31:0] range_in;
    logic        bounds_bad;
    logic        range_wide;

    assign s_fire     = s_valid && s_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign seed_mag   = s_seed_value[31] ? (32'd0 - $unsigned(s_seed_value))
                                         : $unsigned(s_seed_value);
    assign range_in   = $unsigned(s_range_high) - $unsigned(s_range_low);
    assign bounds_bad = s_range_low > s_range_high;
    assign range_wide = range_reg > {1'b0, srng_pkg::MODULUS};

    // seed fold: |base - mag| is already below 2^31, only equality needs folding
    logic [31:0] seed_diff;
    logic [30:0] seed_mj;

    assign seed_diff = (range_reg >= {1'b0, srng_pkg::SEED_BASE})
                     ? range_reg - {1'b0, srng_pkg::SEED_BASE}
                     : {1'b0, srng_pkg::SEED_BASE} - range_reg;
    assign seed_mj   = (seed_diff == {1'b0, srng_pkg::MODULUS}) ? 31'd0 : seed_diff[30:0];

    // shared modular subtractor: a - b into [0, 2^31-1)
    logic [30:0] sub_a, sub_b, sub_res;
    logic [31:0] sub_diff;
    logic [31:0] sub_wrap;

    assign sub_a    = (state_reg == srng_pkg::S_FILL) ? mj_reg : rd_a_reg;
    assign sub_b    = (state_reg == srng_pkg::S_FILL) ? mk_reg : rd_b_reg;
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_wrap = sub_diff + {1'b0, srng_pkg::MODULUS};

    always_comb begin
        priority if (sub_diff == {1'b0, srng_pkg::MODULUS}) begin
            sub_res = srng_pkg::MODULUS - 31'd1;
        end else if (sub_diff[31]) begin
            sub_res = sub_wrap[30:0];
        end else begin
            sub_res = sub_diff[30:0];
        end
    end

    // index arithmetic
    logic [6:0] slot_sum, slot_wrap;
    logic [5:0] mix_partner;
    logic [5:0] lead_step, trail_step;
    logic       fill_last, mix_last, pass_last;

    assign slot_sum    = {1'b0, slot_reg} + {1'b0, srng_pkg::LAG_SHORT};
    assign slot_wrap   = (slot_sum >= {1'b0, srng_pkg::TABLE_LEN})
                       ? slot_sum - {1'b0, srng_pkg::TABLE_LEN} : slot_sum;
    assign mix_partner = (cnt_reg <= srng_pkg::MIX_SPLIT) ? cnt_reg + srng_pkg::MIX_FWD
                                                         : cnt_reg - srng_pkg::MIX_SPLIT;
    assign lead_step   = (lead_reg  == srng_pkg::TABLE_LEN) ? 6'd1 : lead_reg  + 6'd1;
    assign trail_step  = (trail_reg == srng_pkg::TABLE_LEN) ? 6'd1 : trail_reg + 6'd1;
    assign fill_last   = cnt_reg  == srng_pkg::FILL_LAST;
    assign mix_last    = cnt_reg  == srng_pkg::TABLE_LEN;
    assign pass_last   = pass_reg == srng_pkg::MIX_PASS_LAST;

    // scaler operand: wide case offsets the signed first draw into [0, 2^32-4]
    logic [31:0] prep_n;

    always_comb begin
        priority if (!range_wide) begin
            prep_n = {1'b0, r1_reg};
        end else if (par_reg) begin
            prep_n = srng_pkg::WIDE_OFS + {1'b0, r1_reg};
        end else begin
            prep_n = srng_pkg::WIDE_OFS - {1'b0, r1_reg};
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srng_pkg::S_IDLE: begin
                if (s_fire) begin
                    unique case (s_operation)
                        srng_pkg::OP_RESEED: state_next = srng_pkg::S_SEED;
                        srng_pkg::OP_RAW: begin
                            state_next = seeded_reg ? srng_pkg::S_DRAW_RD : srng_pkg::S_DONE;
                        end
                        srng_pkg::OP_BOUNDED: begin
                            state_next = (seeded_reg && !bounds_bad) ? srng_pkg::S_DRAW_RD
                                                                     : srng_pkg::S_DONE;
                        end
                        default: state_next = srng_pkg::S_DONE;
                    endcase
                end
            end
            srng_pkg::S_SEED:   state_next = srng_pkg::S_FILL;
            srng_pkg::S_FILL: begin
                if (fill_last) begin
                    state_next = srng_pkg::S_MIX_RD;
                end
            end
            srng_pkg::S_MIX_RD: state_next = srng_pkg::S_MIX_WR;
            srng_pkg::S_MIX_WR: begin
                state_next = (mix_last && pass_last) ? srng_pkg::S_DONE : srng_pkg::S_MIX_RD;
            end
            srng_pkg::S_DRAW_RD: state_next = srng_pkg::S_DRAW_WR;
            srng_pkg::S_DRAW_WR: begin
                priority if (!bounded_reg) begin
                    state_next = srng_pkg::S_DONE;
                end else if (range_wide && !second_reg) begin
                    state_next = srng_pkg::S_DRAW_RD;
                end else begin
                    state_next = srng_pkg::S_PREP;
                end
            end
            srng_pkg::S_PREP:  state_next = srng_pkg::S_SCALE;
            srng_pkg::S_SCALE: begin
                if (scl_resp.done) begin
                    state_next = srng_pkg::S_DONE;
                end
            end
            srng_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = srng_pkg::S_IDLE;
                end
            end
            default: state_next = srng_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb begin
        s_ready       = state_reg == srng_pkg::S_IDLE;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = sub_res;
        mem_raddr_a   = cnt_reg;
        mem_raddr_b   = mix_partner;
        scl_req.start = 1'b0;
        scl_req.wide  = range_wide;
        scl_req.n     = prep_n;
        scl_req.span  = range_reg;
        unique case (state_reg)
            srng_pkg::S_SEED: begin
                mem_we    = 1'b1;
                mem_waddr = srng_pkg::TABLE_LEN;
                mem_wdata = seed_mj;
            end
            srng_pkg::S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = mk_reg;
            end
            srng_pkg::S_MIX_WR: begin
                mem_we = 1'b1;
            end
            srng_pkg::S_DRAW_RD: begin
                mem_raddr_a = lead_step;
                mem_raddr_b = trail_step;
            end
            srng_pkg::S_DRAW_WR: begin
                mem_we    = 1'b1;
                mem_waddr = lead_step;
            end
            srng_pkg::S_PREP: begin
                scl_req.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register: loads when the result is ready and the slot is free
    always_comb begin
        out_valid_next = out_valid_reg;
        if ((state_reg == srng_pkg::S_DONE) && out_free) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srng_pkg::S_IDLE;
            seeded_reg    <= 1'b0;
            lead_reg      <= 6'd0;
            trail_reg     <= srng_pkg::LAG_SHORT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == srng_pkg::S_MIX_WR) && mix_last && pass_last) begin
                seeded_reg <= 1'b1;
                lead_reg   <= 6'd0;
                trail_reg  <= srng_pkg::LAG_SHORT;
            end else if (state_reg == srng_pkg::S_DRAW_WR) begin
                lead_reg  <= lead_step;
                trail_reg <= trail_step;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            srng_pkg::S_IDLE: begin
                if (s_fire) begin
                    range_reg      <= (s_operation == srng_pkg::OP_RESEED) ? seed_mag : range_in;
                    lo_reg         <= $unsigned(s_range_low);
                    bounded_reg    <= s_operation == srng_pkg::OP_BOUNDED;
                    second_reg     <= 1'b0;
                    res_value_reg  <= '0;
                    res_status_reg <= srng_pkg::STAT_OK;
                    if ((s_operation == srng_pkg::OP_RAW) ||
                        (s_operation == srng_pkg::OP_BOUNDED)) begin
                        if (!seeded_reg) begin
                            res_status_reg <= srng_pkg::STAT_UNSEEDED;
                        end else if ((s_operation == srng_pkg::OP_BOUNDED) && bounds_bad) begin
                            res_status_reg <= srng_pkg::STAT_BOUNDS;
                        end
                    end
                end
            end
            srng_pkg::S_SEED: begin
                mj_reg   <= seed_mj;
                mk_reg   <= 31'd1;
                slot_reg <= srng_pkg::LAG_SHORT;
                cnt_reg  <= 6'd1;
            end
            srng_pkg::S_FILL: begin
                mk_reg   <= sub_res;
                mj_reg   <= mk_reg;
                slot_reg <= slot_wrap[5:0];
                cnt_reg  <= fill_last ? 6'd1 : cnt_reg + 6'd1;
                pass_reg <= 2'd0;
            end
            srng_pkg::S_MIX_WR: begin
                if (mix_last) begin
                    cnt_reg  <= 6'd1;
                    pass_reg <= pass_reg + 2'd1;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                res_value_reg  <= '0;
                res_status_reg <= srng_pkg::STAT_OK;
            end
            srng_pkg::S_DRAW_WR: begin
                res_value_reg  <= {1'b0, sub_res};
                res_status_reg <= srng_pkg::STAT_OK;
                if (second_reg) begin
                    par_reg <= sub_res[0];
                end else begin
                    r1_reg     <= sub_res;
                    second_reg <= 1'b1;
                end
            end
            srng_pkg::S_SCALE: begin
                if (scl_resp.done) begin
                    res_value_reg <= lo_reg + scl_resp.quotient;
                end
            end
            srng_pkg::S_DONE: begin
                if (out_free) begin
                    out_value_reg  <= res_value_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = $signed(out_value_reg);
    assign m_status = out_status_reg;

    // ---------------------------------------------------------------- assertions
    `SRNG_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "s_ready high right after a transfer in")
    `SRNG_ASSERT_IMPL(a_scale_done_state, aclk, aresetn, scl_resp.done, state_reg == srng_pkg::S_SCALE, "scaler result outside the scale wait")
    `SRNG_ASSERT_IMPL(a_scale_latency, aclk, aresetn, scl_resp.done, $past(scl_req.start, 4), "scaler result without a start four cycles earlier")
    `SRNG_ASSERT_IMPL(a_error_value_zero, aclk, aresetn, m_valid && (m_status != srng_pkg::STAT_OK), m_value == 32'sd0, "error result carries a non-zero value")
    `SRNG_ASSERT_IMPL(a_no_draw_unseeded, aclk, aresetn, !seeded_reg, (state_reg != srng_pkg::S_DRAW_RD) && (state_reg != srng_pkg::S_DRAW_WR), "table draw before the first reseed")

endmodule

// ===== rtl/core/srng_scaler.sv =====
// Four-stage scaler: floor(n * span / divisor), divisor 2^31-1 or 2^32-3.
module srng_scaler (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  srng_pkg::scale_req_t    req,
    output srng_pkg::scale_resp_t   resp
);

    logic        v1_reg, v2_reg, v3_reg, done_reg;
    logic        wide1_reg, wide2_reg, wide3_reg;
    logic [63:0] prod_reg;
    logic [31:0] hq_reg;
    logic [33:0] s_reg;
    logic [31:0] qp_reg;
    logic [32:0] s2_reg;
    logic [31:0] quot_reg;

    // stage 2 fold: 2^32 = 3 mod (2^32-3), 2^31 = 1 mod (2^31-1)
    logic [33:0] fold_wide;
    logic [31:0] fold_narrow;
    // stage 3
    logic [1:0]  h2;
    logic [32:0] fold2;
    logic [1:0]  corr;
    logic [33:0] two_mod;

    assign fold_wide = {2'b00, prod_reg[63:32]} + {1'b0, prod_reg[63:32], 1'b0}
                     + {2'b00, prod_reg[31:0]};
    assign fold_narrow = {1'b0, prod_reg[61:31]} + {1'b0, prod_reg[30:0]};

    assign h2      = s_reg[33:32];
    assign fold2   = {31'd0, h2} + {30'd0, h2, 1'b0} + {1'b0, s_reg[31:0]};
    assign two_mod = {2'b00, srng_pkg::MODULUS, 1'b0};

    always_comb begin
        priority if (s_reg >= two_mod) begin
            corr = 2'd2;
        end else if (s_reg >= {3'b000, srng_pkg::MODULUS}) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= {32'd0, req.n} * {32'd0, req.span};
        wide1_reg <= req.wide;

        wide2_reg <= wide1_reg;
        if (wide1_reg) begin
            hq_reg <= prod_reg[63:32];
            s_reg  <= fold_wide;
        end else begin
            hq_reg <= {1'b0, prod_reg[61:31]};
            s_reg  <= {2'b00, fold_narrow};
        end

        wide3_reg <= wide2_reg;
        if (wide2_reg) begin
            qp_reg <= hq_reg + {30'd0, h2};
            s2_reg <= fold2;
        end else begin
            qp_reg <= hq_reg + {30'd0, corr};
            s2_reg <= '0;
        end

        if (wide3_reg && (s2_reg >= {1'b0, srng_pkg::WIDE_DIV})) begin
            quot_reg <= qp_reg + 32'd1;
        end else begin
            quot_reg <= qp_reg;
        end
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quot_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the subtractive lagged random generator core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Fourth operation code: the block must answer it with zero and OK, touching no state.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Own copies of the arithmetic constants, kept apart from the package on purpose.
    localparam longint LAG_MOD      = 64'sd2147483647;
    localparam longint FOLD_BASE    = 64'sd161803398;
    localparam longint WIDE_OFFSET  = 64'sd2147483646;
    localparam longint unsigned WIDE_DIVISOR = 64'd4294967293;
    localparam int     TABLE_DEPTH  = 55;

    localparam int RANDOM_ITEMS  = 1350;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 300;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] seed;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } rng_request_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } rng_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = OP_UNUSED;
    logic signed [31:0] s_seed_value = '0;
    logic signed [31:0] s_range_low = '0;
    logic signed [31:0] s_range_high = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_value;
    logic [1:0]         m_status;

    subtractive_lagged_rng_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_seed_value (s_seed_value),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Generator mirror: the 55-word lag table, the two cursors and the
    // seeded flag, updated as each transfer is accepted on the input side.
    // Entries 1..55 are used; entry 0 is never touched.
    // ------------------------------------------------------------------
    bit [30:0]   lag_table [0:TABLE_DEPTH];
    int unsigned lead_pos   = 0;
    int unsigned trail_pos  = 21;
    bit          table_live = 1'b0;

    // Seeding schedule: fold the seed, scatter it over the table in steps
    // of 21, then four mixing passes against the entry 31 places ahead.
    function automatic void reload_table(logic signed [31:0] seed);
        longint      mag;
        longint      mj;
        longint      mk;
        longint      v;
        int unsigned slot;
        mag = longint'(seed);
        if (mag < 0) mag = -mag;
        mj = FOLD_BASE - mag;
        if (mj < 0) mj = -mj;
        mj = mj % LAG_MOD;
        mk = 1;
        lag_table[TABLE_DEPTH] = mj[30:0];
        for (int unsigned i = 1; i < TABLE_DEPTH; i++) begin
            slot = (21 * i) % TABLE_DEPTH;
            lag_table[slot] = mk[30:0];
            mk = mj - mk;
            if (mk < 0) mk += LAG_MOD;
            mj = longint'(lag_table[slot]);
        end
        for (int pass = 1; pass < 5; pass++) begin
            for (int unsigned i = 1; i <= TABLE_DEPTH; i++) begin
                v = longint'(lag_table[i]) - longint'(lag_table[1 + (i + 30) % TABLE_DEPTH]);
                if (v < 0) v += LAG_MOD;
                lag_table[i] = v[30:0];
            end
        end
        lead_pos   = 0;
        trail_pos  = 21;
        table_live = 1'b1;
    endfunction

    // One step of the lagged recurrence; the difference goes back into the lead slot.
    function automatic longint next_sample();
        int unsigned a;
        int unsigned b;
        longint      r;
        a = lead_pos + 1;
        b = trail_pos + 1;
        if (a > TABLE_DEPTH || a == 0) a = 1;
        if (b > TABLE_DEPTH || b == 0) b = 1;
        r = longint'(lag_table[a]) - longint'(lag_table[b]);
        if (r == LAG_MOD) r--;
        if (r < 0) r += LAG_MOD;
        lag_table[a] = r[30:0];
        lead_pos  = a;
        trail_pos = b;
        return r;
    endfunction

    // Expected reply to one accepted request; advances the mirror as the block should.
    function automatic rng_result_t predict_result(rng_request_t req);
        rng_result_t    res;
        longint         lo;
        longint         hi;
        longint         r1;
        longint         r2;
        longint         total;
        longint unsigned span;
        longint unsigned quot;
        res.value  = '0;
        res.status = srng_pkg::STAT_OK;
        lo = longint'(req.lo);
        hi = longint'(req.hi);
        if (req.op == srng_pkg::OP_RESEED) begin
            reload_table(req.seed);
        end else if (req.op == srng_pkg::OP_RAW || req.op == srng_pkg::OP_BOUNDED) begin
            // unseeded refusal wins over a bound error
            if (!table_live) begin
                res.status = srng_pkg::STAT_UNSEEDED;
            end else if (req.op == srng_pkg::OP_RAW) begin
                r1 = next_sample();
                res.value = r1[31:0];
            end else if (lo > hi) begin
                res.status = srng_pkg::STAT_BOUNDS;
            end else begin
                span = longint'(hi - lo);
                if (span <= longint'(LAG_MOD)) begin
                    r1   = next_sample();
                    quot = (longint'(r1) * span) / longint'(LAG_MOD);
                end else begin
                    // wide span: two draws, parity of the second picks the sign of the first
                    r1 = next_sample();
                    r2 = next_sample();
                    if (r2[0] == 1'b0) r1 = -r1;
                    quot = (longint'(r1 + WIDE_OFFSET) * span) / WIDE_DIVISOR;
                end
                total = lo + longint'(quot);
                res.value = total[31:0];
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    rng_request_t queued_requests [$];
    rng_result_t  awaited_results [$];

    function automatic rng_request_t make_req(logic [1:0] op, logic signed [31:0] seed,
                                              logic signed [31:0] lo, logic signed [31:0] hi);
        rng_request_t req;
        req.op   = op;
        req.seed = seed;
        req.lo   = lo;
        req.hi   = hi;
        return req;
    endfunction

    function automatic rng_request_t random_request();
        rng_request_t req;
        longint       lo;
        longint       hi;
        int unsigned  pick;
        req = make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            req.op = srng_pkg::OP_RESEED;
            case ($urandom_range(0, 5))
                0: req.seed = 32'sh7FFF_FFFF;
                1: req.seed = -32'sh7FFF_FFFF;
                2: req.seed = 32'sd0;
                default: ;
            endcase
            // the most negative value lies outside the seed's range
            if (req.seed == 32'sh8000_0000) req.seed = 32'sh8000_0001;
        end else if (pick < 38) begin
            req.op = srng_pkg::OP_RAW;
        end else if (pick < 94) begin
            req.op = srng_pkg::OP_BOUNDED;
            lo = longint'(req.lo);
            hi = longint'(req.hi);
            case ($urandom_range(0, 7))
                0, 1: begin
                    // narrow span, at most 1000
                    hi = lo + $urandom_range(0, 1000);
                    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
                end
                2, 3: begin
                    // ordered random bounds, narrow or wide as they fall
                    if (lo > hi) begin
                        lo = longint'(req.hi);
                        hi = longint'(req.lo);
                    end
                end
                4: begin
                    // forced wide span across zero
                    lo = -(longint'($urandom_range(0, 32'h7FFF_FFFF)) + 1);
                    hi = longint'($urandom_range(0, 32'h7FFF_FFFF));
                    if (hi - lo <= LAG_MOD) hi = 64'sd2147483647;
                end
                5: begin
                    // span sitting on the narrow/wide boundary
                    lo = -longint'($urandom_range(0, 2));
                    hi = lo + LAG_MOD + longint'($urandom_range(0, 1)) - 1;
                    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
                end
                6: begin
                    // inverted bounds
                    if (lo == hi) hi = lo - 1;
                    if (lo < hi) begin
                        lo = longint'(req.hi);
                        hi = longint'(req.lo);
                    end
                    if (lo < -64'sd2147483647) begin
                        lo = 64'sd5;
                        hi = -64'sd5;
                    end
                end
                default: ; // unsorted, either order
            endcase
            req.lo = lo[31:0];
            req.hi = hi[31:0];
        end else begin
            req.op = OP_UNUSED;
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of transfers separated by random gaps
    // ------------------------------------------------------------------
    rng_request_t live_req;
    int unsigned  burst_left = 0;
    int unsigned  gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // prediction happens on the transfer edge, in accept order
            if (s_valid && s_ready) awaited_results.push_back(predict_result(live_req));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    live_req = queued_requests.pop_front();
                    s_operation  <= live_req.op;
                    s_seed_value <= live_req.seed;
                    s_range_low  <= live_req.lo;
                    s_range_high <= live_req.hi;
                    s_valid      <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: the stall mode is redrawn whenever its phase runs out, and one
    // long hold-off once enough results have gone by, so the output register
    // fills and the block stops taking input.
    // ------------------------------------------------------------------
    int unsigned results_seen = 0;
    int unsigned stall_mode   = 0;
    int unsigned phase_cycles = 0;
    int unsigned hold_cycles  = 0;
    bit          hold_done    = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done   <= 1'b1;
            hold_cycles <= LONG_HOLD;
            m_ready     <= 1'b0;
        end else begin
            if (phase_cycles == 0) begin
                stall_mode   <= $urandom_range(0, 2);
                phase_cycles <= $urandom_range(16, 96);
            end else begin
                phase_cycles <= phase_cycles - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------
    int unsigned fault_count = 0;
    rng_result_t oldest_result;

    task automatic flag_fault(string what, rng_result_t want);
        if (fault_count < 10)
            $display("[%0t] %s: value exp %0d got %0d, status exp %0d got %0d",
                     $realtime, what, want.value, m_value, want.status, m_status);
        fault_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (awaited_results.size() == 0) begin
                oldest_result.value  = 'x;
                oldest_result.status = 'x;
                flag_fault("unexpected transfer", oldest_result);
            end else begin
                oldest_result = awaited_results.pop_front();
                if (m_value !== oldest_result.value || m_status !== oldest_result.status)
                    flag_fault("mismatch", oldest_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed items, then the random body, then drain
    // ------------------------------------------------------------------
    initial begin
        // draws before any reseed are refused; unseeded beats the bound error
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom, 32'sd9, -32'sd9));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom, -32'sd4, 32'sd40));
        queued_requests.push_back(make_req(OP_UNUSED, $urandom, $urandom, $urandom));
        // seeding at the extremes, and at the fold base itself so the fold gives zero
        queued_requests.push_back(make_req(srng_pkg::OP_RESEED, 32'sd0, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom, -32'sd5, -32'sd5));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom, 32'sd5, -32'sd5));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           32'sd0, 32'sh7FFF_FFFF));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           -32'sd1, 32'sh7FFF_FFFF));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           32'sh8000_0000, 32'sh7FFF_FFFF));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           32'sh8000_0000, 32'sh8000_0000));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           32'sh7FFF_FFFF, 32'sh8000_0000));
        queued_requests.push_back(make_req(OP_UNUSED, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                                           32'shFFFF_FFFF));
        queued_requests.push_back(make_req(srng_pkg::OP_RESEED, 32'sh7FFF_FFFF,
                                           $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RESEED, -32'sh7FFF_FFFF,
                                           $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RESEED, 32'sd161803398,
                                           $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_BOUNDED, $urandom,
                                           32'sh8000_0000, 32'sd1));
        queued_requests.push_back(make_req(srng_pkg::OP_RESEED, -32'sd161803398,
                                           $urandom, $urandom));
        queued_requests.push_back(make_req(srng_pkg::OP_RAW, $urandom, $urandom, $urandom));
        for (int n = 0; n < RANDOM_ITEMS; n++) queued_requests.push_back(random_request());

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_requests.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        // let any stray result show up before judging
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/srng_pkg.sv
rtl/core/srng_scaler.sv
rtl/core/subtractive_lagged_rng_core.sv
verif/tb.sv
